>>> rtl/ttd_pkg.sv
// shared types, constants and score helpers for the transposition table
`timescale 1ns / 1ps

package ttd_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_INDEX_BITS    = 2'd0,
		REG_WIN_THRESHOLD = 2'd1,
		REG_EMPTY_SCORE   = 2'd2,
		REG_EMPTY_EVAL    = 2'd3
	} cfg_reg_t;

	// item operation codes
	typedef enum logic {
		CMD_PROBE = 1'b0,
		CMD_STORE = 1'b1
	} cmd_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [4:0]         RESET_INDEX_BITS    = 5'd16;
	localparam logic [14:0]        RESET_WIN_THRESHOLD = 15'd31000;
	localparam logic signed [15:0] RESET_EMPTY_SCORE   = 16'sh8000;
	localparam logic signed [15:0] RESET_EMPTY_EVAL    = 16'sh8000;

	localparam logic [5:0] AGE_MASK = 6'h3F;

	// queue depths between the parts
	localparam int FRONTQ_DEPTH = 4;
	localparam int OUTQ_DEPTH   = 4;
	localparam int OUTQ_CNT_W   = $clog2(OUTQ_DEPTH + 1);

	// one table entry as held in memory
	typedef struct packed {
		logic [31:0]        tag;
		logic signed [15:0] score;
		logic signed [15:0] eval;
		logic [7:0]         depth;
		logic [1:0]         bound;
		logic [5:0]         age;
		logic               mnull;
		logic [15:0]        move;
	} entry_t;

	// classified item handed from front to back (slot travels beside it)
	typedef struct packed {
		cmd_t               op;
		logic [31:0]        tag;
		logic signed [15:0] score_st;
		logic signed [15:0] eval;
		logic [1:0]         bound;
		logic [15:0]        move;
		logic               mnull;
		logic [7:0]         depth;
		logic [7:0]         ply;
		logic [5:0]         age;
	} item_t;

	// one result item
	typedef struct packed {
		logic               hit;
		logic signed [15:0] score_raw;
		logic signed [15:0] score_adj;
		logic signed [15:0] eval;
		logic [7:0]         depth;
		logic [1:0]         bound;
		logic [5:0]         age;
		logic [15:0]        move;
		logic               mnull;
	} res_t;

	// mate score shift by ply: away from zero on store, toward zero on probe
	function automatic logic signed [15:0] shift_mate(
		input logic signed [15:0] s,
		input logic [7:0]         ply,
		input logic [14:0]        thr,
		input logic               away
	);
		logic signed [16:0] mag;
		logic signed [17:0] wide;
		logic signed [17:0] plyw;
		logic signed [17:0] sum;
		logic               add;
		mag  = s[15] ? -(17'(s)) : 17'(s);
		wide = 18'(s);
		plyw = $signed({10'd0, ply});
		add  = ((s > 16'sd0) == away);
		sum  = add ? (wide + plyw) : (wide - plyw);
		if (mag < $signed({2'b00, thr})) begin
			shift_mate = s;
		end else if (sum > 18'sd32767) begin
			shift_mate = 16'sh7FFF;
		end else if (sum < -18'sd32768) begin
			shift_mate = 16'sh8000;
		end else begin
			shift_mate = sum[15:0];
		end
	endfunction

endpackage

>>> rtl/ttd_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module ttd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/ttd_fifo.sv
// small flop-based queue with count
`timescale 1ns / 1ps

module ttd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/ttd_front.sv
// front part: accepts items, derives slot, tag and stored score, queues them
`timescale 1ns / 1ps

module ttd_front import ttd_pkg::*; #(
	parameter int ENTRY_INDEX_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        cmd,
	input  logic [63:0]                 key,
	input  logic signed [15:0]          score,
	input  logic signed [15:0]          eval,
	input  logic [1:0]                  bound_type,
	input  logic [15:0]                 best_move,
	input  logic                        move_is_null,
	input  logic [7:0]                  depth,
	input  logic [7:0]                  ply,
	input  logic [7:0]                  age,
	input  logic [4:0]                  index_bits,
	input  logic [14:0]                 win_threshold,
	input  logic                        clearing,
	input  logic                        q_pop,
	output logic                        q_empty,
	output logic [ENTRY_INDEX_BITS-1:0] q_slot,
	output item_t                       q_item
);

	localparam int IW = ENTRY_INDEX_BITS;
	localparam int QW = IW + $bits(item_t);

	logic [IW-1:0] mask;
	logic [IW-1:0] slot;
	item_t         item;
	logic          q_full;
	logic [QW-1:0] q_rdata;

	// index mask from index_bits, saturating at the table size
	always_comb begin
		for (int i = 0; i < IW; i++) begin
			mask[i] = (index_bits > 5'(i));
		end
	end

	assign slot = key[IW-1:0] & mask;

	// classify the item; mate scores get their ply shift here
	always_comb begin
		item.op       = cmd_t'(cmd);
		item.tag      = key[63:32];
		item.score_st = shift_mate(score, ply, win_threshold, 1'b1);
		item.eval     = eval;
		item.bound    = bound_type;
		item.move     = best_move;
		item.mnull    = move_is_null;
		item.depth    = depth;
		item.ply      = ply;
		item.age      = age[5:0] & AGE_MASK;
	end

	// no items while the table is being cleared
	assign full = clearing || q_full;

	ttd_fifo #(
		.WIDTH (QW),
		.DEPTH (FRONTQ_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push && !full),
		.wdata  ({slot, item}),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty),
		.count  ()
	);

	assign q_slot = q_rdata[QW-1 -: IW];
	assign q_item = item_t'(q_rdata[$bits(item_t)-1:0]);

endmodule

>>> rtl/ttd_back.sv
// back part: clearing pass, read-modify-write of the table, result queue
`timescale 1ns / 1ps

module ttd_back import ttd_pkg::*; #(
	parameter int ENTRY_INDEX_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [14:0]                 win_threshold,
	input  logic                        q_empty,
	output logic                        q_pop,
	input  logic [ENTRY_INDEX_BITS-1:0] q_slot,
	input  item_t                       q_item,
	output logic                        clearing,
	output logic                        empty,
	input  logic                        pop,
	output res_t                        res
);

	localparam int IW = ENTRY_INDEX_BITS;
	localparam int EW = $bits(entry_t);
	localparam int CW = OUTQ_CNT_W + 1;

	logic                  clearing_q;
	logic [IW-1:0]         clr_idx_q;

	logic                  vld_s1;
	item_t                 item_s1;
	logic [IW-1:0]         slot_s1;

	logic                  wr_vld_q;
	logic [IW-1:0]         wr_addr_q;
	entry_t                wr_data_q;

	logic                  vld_s2;
	logic                  hit_s2;
	logic                  zero_s2;
	entry_t                ent_s2;
	logic [7:0]            ply_s2;

	logic [EW-1:0]         rdata;
	entry_t                cur;
	entry_t                upd;
	entry_t                clr_ent;
	logic                  tag_match;
	logic                  is_store;
	logic                  replace;
	logic                  do_write;
	logic                  ram_we;
	logic [IW-1:0]         ram_waddr;
	entry_t                ram_wdata;
	logic [OUTQ_CNT_W-1:0] out_count;
	logic                  credit_ok;
	logic                  issue;
	res_t                  res_s2;
	logic [$bits(res_t)-1:0] out_rdata;

	assign clearing = clearing_q;

	// clearing pass: one entry per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (&clr_idx_q) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_comb begin
		clr_ent       = '0;
		clr_ent.score = RESET_EMPTY_SCORE;
		clr_ent.eval  = RESET_EMPTY_EVAL;
	end

	// issue only when the result queue has room for everything in flight
	assign credit_ok = (CW'(out_count) + CW'(vld_s1) + CW'(vld_s2)) < CW'(OUTQ_DEPTH);
	assign issue     = !clearing_q && !q_empty && credit_ok;
	assign q_pop     = issue;

	// stage 1 holds the item while the entry is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			item_s1 <= q_item;
			slot_s1 <= q_slot;
		end
	end

	// forward the previous write, which the read of the same edge missed
	assign cur = (wr_vld_q && (wr_addr_q == slot_s1)) ? wr_data_q : entry_t'(rdata);

	// replacement decision and updated entry
	always_comb begin
		tag_match = (cur.tag == item_s1.tag);
		is_store  = (item_s1.op == CMD_STORE);
		replace   = (item_s1.age != cur.age) || (item_s1.depth >= cur.depth);
		upd       = cur;
		upd.tag   = item_s1.tag;
		upd.score = item_s1.score_st;
		upd.eval  = item_s1.eval;
		upd.depth = item_s1.depth;
		upd.bound = item_s1.bound;
		upd.age   = item_s1.age;
		if (!item_s1.mnull || !tag_match) begin
			upd.move  = item_s1.move;
			upd.mnull = item_s1.mnull;
		end
		do_write  = vld_s1 && is_store && replace;
	end

	// write port: clearing pass or a replacing store
	always_comb begin
		ram_we    = clearing_q || do_write;
		ram_waddr = clearing_q ? clr_idx_q : slot_s1;
		ram_wdata = clearing_q ? clr_ent : upd;
	end

	ttd_ram #(
		.WIDTH (EW),
		.DEPTH (1 << IW)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (q_slot),
		.rdata (rdata)
	);

	// last write, kept for forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= 1'b0;
		end else begin
			wr_vld_q <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			wr_addr_q <= ram_waddr;
			wr_data_q <= ram_wdata;
		end
	end

	// stage 2 holds the entry as it stands after the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			hit_s2  <= is_store ? replace : tag_match;
			zero_s2 <= !is_store && !tag_match;
			ent_s2  <= do_write ? upd : cur;
			ply_s2  <= item_s1.ply;
		end
	end

	// result build; a probe miss gives all zeros
	always_comb begin
		res_s2.hit       = hit_s2;
		res_s2.score_raw = ent_s2.score;
		res_s2.score_adj = shift_mate(ent_s2.score, ply_s2, win_threshold, 1'b0);
		res_s2.eval      = ent_s2.eval;
		res_s2.depth     = ent_s2.depth;
		res_s2.bound     = ent_s2.bound;
		res_s2.age       = ent_s2.age;
		res_s2.move      = ent_s2.move;
		res_s2.mnull     = ent_s2.mnull;
		if (zero_s2) begin
			res_s2 = '0;
		end
	end

	ttd_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (OUTQ_DEPTH)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (vld_s2),
		.wdata  (res_s2),
		.pop    (pop),
		.rdata  (out_rdata),
		.full   (),
		.empty  (empty),
		.count  (out_count)
	);

	assign res = res_t'(out_rdata);

endmodule

>>> rtl/transposition_table_depth_age_replace_top.sv
// top level of the depth-preferred transposition table with age replacement
`timescale 1ns / 1ps

// Direct-mapped transposition table of 2**ENTRY_INDEX_BITS entries held in one
// ram. After reset a clearing pass writes every entry (tag zero, empty score and
// eval at their reset values) with full high; configuration writes are taken
// during it. Each probe or store is one read-modify-write of the table: read,
// decide and write back, then shape the result; an accepted item passes the
// front queue, the read stage and the result stage before its result enters the
// result queue. Writes are forwarded to the next read, so one item per cycle is
// sustained as long as results are popped; the four-entry result queue sets how
// far the result side may lag before push is held off. Writes to the empty score
// and empty eval registers have no effect on the table, as cleared entries always
// hold the reset values.

module transposition_table_depth_age_replace_top import ttd_pkg::*; #(
	parameter int ENTRY_INDEX_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// items in
	input  logic                  push,
	output logic                  full,
	input  logic                  cmd,
	input  logic [63:0]           key,
	input  logic signed [15:0]    score,
	input  logic signed [15:0]    eval,
	input  logic [1:0]            bound_type,
	input  logic [15:0]           best_move,
	input  logic                  move_is_null,
	input  logic [7:0]            depth,
	input  logic [7:0]            ply,
	input  logic [7:0]            age,
	// results out
	output logic                  empty,
	input  logic                  pop,
	output logic                  hit,
	output logic signed [15:0]    score_raw,
	output logic signed [15:0]    score_adjusted,
	output logic signed [15:0]    eval_out,
	output logic [7:0]            depth_out,
	output logic [1:0]            bound_out,
	output logic [5:0]            age_out,
	output logic [15:0]           move_out,
	output logic                  move_null_out
);

	logic [4:0]                  index_bits_q;
	logic [14:0]                 win_threshold_q;
	logic                        clearing;
	logic                        q_empty;
	logic                        q_pop;
	logic [ENTRY_INDEX_BITS-1:0] q_slot;
	item_t                       q_item;
	res_t                        res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q    <= RESET_INDEX_BITS;
			win_threshold_q <= RESET_WIN_THRESHOLD;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_INDEX_BITS:    index_bits_q    <= cfg_wdata[4:0];
				REG_WIN_THRESHOLD: win_threshold_q <= cfg_wdata[14:0];
				REG_EMPTY_SCORE:   ;
				REG_EMPTY_EVAL:    ;
			endcase
		end
	end

	ttd_front #(
		.ENTRY_INDEX_BITS (ENTRY_INDEX_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.cmd           (cmd),
		.key           (key),
		.score         (score),
		.eval          (eval),
		.bound_type    (bound_type),
		.best_move     (best_move),
		.move_is_null  (move_is_null),
		.depth         (depth),
		.ply           (ply),
		.age           (age),
		.index_bits    (index_bits_q),
		.win_threshold (win_threshold_q),
		.clearing      (clearing),
		.q_pop         (q_pop),
		.q_empty       (q_empty),
		.q_slot        (q_slot),
		.q_item        (q_item)
	);

	ttd_back #(
		.ENTRY_INDEX_BITS (ENTRY_INDEX_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.win_threshold (win_threshold_q),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.q_slot        (q_slot),
		.q_item        (q_item),
		.clearing      (clearing),
		.empty         (empty),
		.pop           (pop),
		.res           (res)
	);

	// result fields
	assign hit            = res.hit;
	assign score_raw      = res.score_raw;
	assign score_adjusted = res.score_adj;
	assign eval_out       = res.eval;
	assign depth_out      = res.depth;
	assign bound_out      = res.bound;
	assign age_out        = res.age;
	assign move_out       = res.move;
	assign move_null_out  = res.mnull;

endmodule
